### hw/rtl/rts_pkg.sv
// Response transmit sequencer: shared types and code constants.
// Used by rts_apb, rts_engine and response_transmit_sequencer.
`default_nettype none

package rts_pkg;

	localparam int SENT_BITS      = 40;
	localparam int CHUNK_BITS     = 25;
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 3;
	localparam logic [CHUNK_BITS-1:0] MAX_CHUNK_RESET = CHUNK_BITS'(1048576);

	typedef enum logic [2:0] {
		ACT_BEGIN     = 3'd0,
		ACT_ATTACH    = 3'd1,
		ACT_IO_RESULT = 3'd2,
		ACT_WRITABLE  = 3'd3,
		ACT_RESP_DONE = 3'd4,
		ACT_DISCARD   = 3'd5,
		ACT_RESET     = 3'd6
	} action_t;

	typedef enum logic [3:0] {
		DEC_NOOP          = 4'd0,
		DEC_ERROR_CLOSE   = 4'd1,
		DEC_ARM_WRITABLE  = 4'd2,
		DEC_SEND_HEADERS  = 4'd3,
		DEC_SHUT_READ     = 4'd4,
		DEC_START_FILE    = 4'd5,
		DEC_RESUME_FILE   = 4'd6,
		DEC_DONE_KEEP     = 4'd7,
		DEC_DONE_CLOSE    = 4'd8
	} decision_t;

	typedef enum logic [1:0] {
		AFT_CLOSE     = 2'd0,
		AFT_SHUT_READ = 2'd1,
		AFT_KEEPALIVE = 2'd2
	} after_t;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_ORDINARY  = 2'd1,
		KIND_TOO_LARGE = 2'd2,
		KIND_UNAVAIL   = 2'd3
	} reply_class_t;

	typedef enum logic [1:0] {
		IO_OK          = 2'd0,
		IO_WOULD_BLOCK = 2'd1,
		IO_INTERRUPTED = 2'd2,
		IO_ERROR       = 2'd3
	} io_status_t;

	localparam logic IO_KIND_HDR  = 1'b0;
	localparam logic IO_KIND_FILE = 1'b1;

	localparam logic REG_MAX_CHUNK = 1'b0;

	typedef struct packed {
		decision_t decision;
		after_t    after_action;
		logic      rejected;
	} rts_status_t;

endpackage

`default_nettype wire

### hw/rtl/response_transmit_sequencer.sv
// Response transmit sequencer top level: input register, event engine, result register.
// An event passes the input register, then the result register (two register stages).
// Throughput: one event per cycle unless stalled; the state update is one rts_engine pass.
// Input stalls only while the result register is full and stalled.
// Reset clears all response state; max_chunk resets to 1048576.
// Depends on rts_pkg, rts_apb, rts_engine.
`default_nettype none

module response_transmit_sequencer
	import rts_pkg::*;
#(
	parameter int HEADER_LEN_BITS = 16,
	parameter int FILE_LEN_BITS   = 40
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [2:0]                 action,
	input  wire logic [HEADER_LEN_BITS-1:0] header_len,
	input  wire logic [1:0]                 reply_class,
	input  wire logic                       keep_alive,
	input  wire logic                       shut_after_hdr,
	input  wire logic [FILE_LEN_BITS-1:0]   file_length,
	input  wire logic                       io_kind,
	input  wire logic [1:0]                 io_status,
	input  wire logic [SENT_BITS-1:0]       sent_bytes,
	input  wire logic                       link_draining,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [3:0]                 decision,
	output logic      [HEADER_LEN_BITS-1:0] header_offset,
	output logic      [HEADER_LEN_BITS-1:0] header_remaining,
	output logic      [CHUNK_BITS-1:0]      file_chunk,
	output logic      [1:0]                 after_action,
	output logic                            rejected,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [APB_ADDR_BITS-1:0]   paddr,
	input  wire logic [APB_DATA_BITS-1:0]   pwdata,
	output logic      [APB_DATA_BITS-1:0]   prdata,
	output logic                            pready
);

	logic                       valid_s1;
	logic [2:0]                 action_s1;
	logic [HEADER_LEN_BITS-1:0] header_len_s1;
	logic [1:0]                 reply_class_s1;
	logic                       keep_alive_s1, drain_s1, io_kind_s1, draining_s1;
	logic [FILE_LEN_BITS-1:0]   file_length_s1;
	logic [1:0]                 io_status_s1;
	logic [SENT_BITS-1:0]       sent_bytes_s1;

	logic                       valid_s2;
	rts_status_t                status_s2;
	logic [HEADER_LEN_BITS-1:0] header_offset_s2, header_remaining_s2;
	logic [CHUNK_BITS-1:0]      file_chunk_s2;

	logic                       advance, fire;
	logic [CHUNK_BITS-1:0]      max_chunk;
	rts_status_t                status;
	logic [HEADER_LEN_BITS-1:0] hdr_offset_c, hdr_remaining_c;
	logic [CHUNK_BITS-1:0]      file_chunk_c;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	rts_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_chunk (max_chunk)
	);

	rts_engine #(
		.HEADER_LEN_BITS (HEADER_LEN_BITS),
		.FILE_LEN_BITS   (FILE_LEN_BITS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.action         (action_s1),
		.header_len     (header_len_s1),
		.reply_class    (reply_class_s1),
		.keep_alive     (keep_alive_s1),
		.shut_after_hdr (drain_s1),
		.file_length    (file_length_s1),
		.io_kind        (io_kind_s1),
		.io_status      (io_status_s1),
		.sent_bytes     (sent_bytes_s1),
		.link_draining  (draining_s1),
		.max_chunk      (max_chunk),
		.status         (status),
		.header_offset  (hdr_offset_c),
		.header_remaining (hdr_remaining_c),
		.file_chunk     (file_chunk_c)
	);

	// capture a beat whenever the input register is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action_s1      <= action;
			header_len_s1  <= header_len;
			reply_class_s1 <= reply_class;
			keep_alive_s1  <= keep_alive;
			drain_s1       <= shut_after_hdr;
			file_length_s1 <= file_length;
			io_kind_s1     <= io_kind;
			io_status_s1   <= io_status;
			sent_bytes_s1  <= sent_bytes;
			draining_s1    <= link_draining;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2           <= status;
			header_offset_s2    <= hdr_offset_c;
			header_remaining_s2 <= hdr_remaining_c;
			file_chunk_s2       <= file_chunk_c;
		end
	end

	assign out_valid        = valid_s2;
	assign decision         = status_s2.decision;
	assign after_action     = status_s2.after_action;
	assign rejected         = status_s2.rejected;
	assign header_offset    = header_offset_s2;
	assign header_remaining = header_remaining_s2;
	assign file_chunk       = file_chunk_s2;

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room downstream");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |=> valid_s1)
		else $error("pending beat dropped while output stalled");

	a_reject_code: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status.rejected |->
			status.decision == DEC_NOOP || status.decision == DEC_ERROR_CLOSE)
		else $error("refused event with action decision");

endmodule

`default_nettype wire

### hw/rtl/rts_apb.sv
// Configuration register block: max_chunk behind an APB-style port.
// Depends on rts_pkg.
`default_nettype none

module rts_apb
	import rts_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready,
	output logic      [CHUNK_BITS-1:0]    max_chunk
);

	logic [CHUNK_BITS-1:0] max_chunk_q;
	logic                  reg_sel;

	assign reg_sel   = (paddr[APB_ADDR_BITS-1] == REG_MAX_CHUNK);
	assign pready    = 1'b1;
	assign max_chunk = max_chunk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= MAX_CHUNK_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_chunk_q <= pwdata[CHUNK_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = APB_DATA_BITS'(max_chunk_q);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rts_engine.sv
// Response state and per-event next-state logic; result fields from next state.
// Depends on rts_pkg.
`default_nettype none

module rts_engine
	import rts_pkg::*;
#(
	parameter int HEADER_LEN_BITS = 16,
	parameter int FILE_LEN_BITS   = 40
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire logic [2:0]                 action,
	input  wire logic [HEADER_LEN_BITS-1:0] header_len,
	input  wire logic [1:0]                 reply_class,
	input  wire logic                       keep_alive,
	input  wire logic                       shut_after_hdr,
	input  wire logic [FILE_LEN_BITS-1:0]   file_length,
	input  wire logic                       io_kind,
	input  wire logic [1:0]                 io_status,
	input  wire logic [SENT_BITS-1:0]       sent_bytes,
	input  wire logic                       link_draining,
	input  wire logic [CHUNK_BITS-1:0]      max_chunk,
	output rts_status_t                     status,
	output logic      [HEADER_LEN_BITS-1:0] header_offset,
	output logic      [HEADER_LEN_BITS-1:0] header_remaining,
	output logic      [CHUNK_BITS-1:0]      file_chunk
);

	localparam int FCW = (FILE_LEN_BITS > SENT_BITS) ? FILE_LEN_BITS : SENT_BITS;
	localparam int MCW = (FILE_LEN_BITS > CHUNK_BITS) ? FILE_LEN_BITS : CHUNK_BITS;

	logic [HEADER_LEN_BITS-1:0] hdr_length_q, hdr_sent_q;
	logic                       hdr_present_q, keep_q, drain_q, file_present_q;
	reply_class_t               kind_q;
	logic [FILE_LEN_BITS-1:0]   file_left_q;

	logic [HEADER_LEN_BITS-1:0] hdr_length_n, hdr_sent_n, hdr_gap;
	logic                       hdr_present_n, keep_n, drain_n, file_present_n;
	reply_class_t               kind_n;
	logic [FILE_LEN_BITS-1:0]   file_left_n;
	decision_t                  dec;
	decision_t                  done_dec;
	logic                       rej;
	after_t                     aft;

	assign hdr_gap  = hdr_length_q - hdr_sent_q;
	assign done_dec = keep_q ? DEC_DONE_KEEP : DEC_DONE_CLOSE;

	always_comb begin
		hdr_length_n   = hdr_length_q;
		hdr_sent_n     = hdr_sent_q;
		hdr_present_n  = hdr_present_q;
		kind_n         = kind_q;
		keep_n         = keep_q;
		drain_n        = drain_q;
		file_present_n = file_present_q;
		file_left_n    = file_left_q;
		dec            = DEC_NOOP;
		rej            = 1'b0;
		unique case (action_t'(action))
			ACT_BEGIN: begin
				if (header_len == '0) begin
					dec = DEC_ERROR_CLOSE;
					rej = 1'b1;
				end else begin
					kind_n        = reply_class_t'(reply_class);
					hdr_length_n  = header_len;
					hdr_sent_n    = '0;
					hdr_present_n = 1'b1;
					keep_n        = keep_alive;
					drain_n       = shut_after_hdr;
					dec           = DEC_SEND_HEADERS;
				end
			end
			ACT_ATTACH: begin
				if (file_length == '0) begin
					rej = 1'b1;
				end else begin
					file_present_n = 1'b1;
					file_left_n    = file_length;
				end
			end
			ACT_IO_RESULT: begin
				if (io_status_t'(io_status) == IO_WOULD_BLOCK) begin
					dec = DEC_ARM_WRITABLE;
				end else if (io_status_t'(io_status) == IO_INTERRUPTED) begin
					dec = (io_kind == IO_KIND_FILE) ? DEC_NOOP : DEC_ERROR_CLOSE;
				end else if (io_status_t'(io_status) == IO_ERROR || sent_bytes == '0) begin
					dec = DEC_ERROR_CLOSE;
				end else if (io_kind == IO_KIND_HDR) begin
					if (!hdr_present_q || hdr_length_q == '0) begin
						dec = DEC_ERROR_CLOSE;
					end else begin
						if (sent_bytes >= SENT_BITS'(hdr_gap)) begin
							hdr_sent_n = hdr_length_q;
						end else begin
							hdr_sent_n = hdr_sent_q + sent_bytes[HEADER_LEN_BITS-1:0];
						end
						if (hdr_sent_n != hdr_length_q) begin
							dec = DEC_SEND_HEADERS;
						end else if (drain_q) begin
							dec = DEC_SHUT_READ;
						end else if (file_present_q && file_left_q != '0) begin
							dec = DEC_START_FILE;
						end else begin
							dec = done_dec;
						end
					end
				end else begin
					if (file_left_q == '0) begin
						dec = done_dec;
					end else begin
						if (FCW'(sent_bytes) >= FCW'(file_left_q)) begin
							file_left_n = '0;
						end else begin
							file_left_n = file_left_q - FILE_LEN_BITS'(sent_bytes);
						end
						dec = (file_left_n != '0) ? DEC_RESUME_FILE : done_dec;
					end
				end
			end
			ACT_WRITABLE: begin
				if (file_present_q && file_left_q != '0 &&
					(!hdr_present_q || hdr_sent_q >= hdr_length_q)) begin
					dec = DEC_RESUME_FILE;
				end else if (kind_q != KIND_NONE && hdr_present_q &&
					hdr_length_q != '0 && hdr_sent_q < hdr_length_q) begin
					dec = DEC_SEND_HEADERS;
				end
			end
			ACT_DISCARD: begin
				hdr_present_n = 1'b0;
				hdr_length_n  = '0;
				hdr_sent_n    = '0;
			end
			ACT_RESET: begin
				hdr_present_n  = 1'b0;
				hdr_length_n   = '0;
				hdr_sent_n     = '0;
				kind_n         = KIND_NONE;
				keep_n         = 1'b0;
				drain_n        = 1'b0;
				file_present_n = 1'b0;
				file_left_n    = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (link_draining && kind_n == KIND_TOO_LARGE) begin
			aft = AFT_SHUT_READ;
		end else if (kind_n == KIND_UNAVAIL) begin
			aft = AFT_CLOSE;
		end else begin
			aft = keep_n ? AFT_KEEPALIVE : AFT_CLOSE;
		end
	end

	always_comb begin
		if (MCW'(file_left_n) > MCW'(max_chunk)) begin
			file_chunk = max_chunk;
		end else begin
			file_chunk = CHUNK_BITS'(file_left_n);
		end
	end

	assign header_offset       = hdr_sent_n;
	assign header_remaining    = hdr_length_n - hdr_sent_n;
	assign status.decision     = dec;
	assign status.after_action = aft;
	assign status.rejected     = rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_length_q   <= '0;
			hdr_sent_q     <= '0;
			hdr_present_q  <= 1'b0;
			kind_q         <= KIND_NONE;
			keep_q         <= 1'b0;
			drain_q        <= 1'b0;
			file_present_q <= 1'b0;
			file_left_q    <= '0;
		end else if (fire) begin
			hdr_length_q   <= hdr_length_n;
			hdr_sent_q     <= hdr_sent_n;
			hdr_present_q  <= hdr_present_n;
			kind_q         <= kind_n;
			keep_q         <= keep_n;
			drain_q        <= drain_n;
			file_present_q <= file_present_n;
			file_left_q    <= file_left_n;
		end
	end

	a_sent_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_sent_q <= hdr_length_q)
		else $error("header offset past header length");

	a_present_len: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_present_q == (hdr_length_q != '0))
		else $error("header present flag disagrees with length");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(file_left_q) && $stable(hdr_sent_q))
		else $error("state moved without an event");

endmodule

`default_nettype wire
